// ===== src/positional_list_engine_core_macros.svh =====
// Assertion macros shared by the positional list engine RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_CORE_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define PLE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("positional list engine assertion failed");
// Next-cycle implication, disabled during reset.
`define PLE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("positional list engine assertion failed");
`else
`define PLE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PLE_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/ple_pkg.sv =====
// Shared types and codes for the positional list engine.
// Depends on nothing; used by ple_cell and positional_list_engine_core.
package ple_pkg;

    typedef enum logic [1:0] {
        MODE_GET    = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_LOCATE = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_POS = 2'd1,
        ST_FULL    = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } fsm_state_t;

    typedef struct packed {
        mode_t              mode;
        logic [7:0]         position;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] read_value;
        logic [7:0]         found_position;
        logic [7:0]         list_length;
    } rsp_t;

    // Search token handed from cell to cell.
    typedef struct packed {
        logic               tok;
        logic               hit;
        logic signed [31:0] data;
    } carry_t;

    // Request information broadcast to every cell.
    typedef struct packed {
        mode_t              mode;
        logic signed [31:0] value;
        logic               ins_en;
        logic               del_en;
    } cell_ctl_t;

endpackage

// ===== src/ple_cell.sv =====
// One list slot: holds one entry, shifts with its neighbors, and passes the search token on.
// Depends on ple_pkg.
module ple_cell #(
    parameter int CAPACITY = 128,
    parameter int INDEX    = 0
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ple_pkg::cell_ctl_t                ctl,
    input  logic [$clog2(CAPACITY)-1:0]       tgt,
    input  logic [$clog2(CAPACITY+1)-1:0]     count,
    input  logic signed [31:0]                entry_left,
    input  logic signed [31:0]                entry_right,
    output logic signed [31:0]                entry,
    input  ple_pkg::carry_t                   carry_in,
    input  logic [$clog2(CAPACITY+1)-1:0]     fpos_in,
    output ple_pkg::carry_t                   carry_out,
    output logic [$clog2(CAPACITY+1)-1:0]     fpos_out
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_SLOT = CNT_W'(INDEX);
    localparam logic [CNT_W-1:0] MY_POS = CNT_W'(INDEX + 1);

    logic signed [31:0]   entry_reg;
    logic signed [31:0]   entry_next;
    ple_pkg::carry_t      carry_reg;
    ple_pkg::carry_t      carry_next;
    logic [CNT_W-1:0]     fpos_reg;
    logic [CNT_W-1:0]     fpos_next;
    logic                 is_tgt;
    logic                 above_tgt;
    logic                 active;
    logic                 match;

    assign is_tgt    = (MY_IDX == tgt);
    assign above_tgt = (MY_IDX > tgt);
    assign active    = (MY_SLOT < count);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.ins_en)
        begin
            if (is_tgt)
            begin
                entry_next = ctl.value;
            end
            else if (above_tgt)
            begin
                entry_next = entry_left;
            end
        end
        else if (ctl.del_en && (is_tgt || above_tgt))
        begin
            entry_next = entry_right;
        end
    end

    always_comb
    begin
        match = 1'b0;
        if (ctl.mode inside {ple_pkg::MODE_GET, ple_pkg::MODE_DELETE})
        begin
            match = is_tgt;
        end
        else if (ctl.mode == ple_pkg::MODE_LOCATE)
        begin
            match = active && (entry_reg == ctl.value);
        end

        carry_next = carry_in;
        fpos_next  = fpos_in;
        if (!carry_in.hit)
        begin
            carry_next.hit  = match;
            carry_next.data = entry_reg;
            fpos_next       = MY_POS;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        fpos_reg  <= fpos_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carry_reg <= '0;
        end
        else
        begin
            carry_reg <= carry_next;
        end
    end

    assign entry     = entry_reg;
    assign carry_out = carry_reg;
    assign fpos_out  = fpos_reg;

endmodule

// ===== src/positional_list_engine_core.sv =====
// Top level of the positional list engine: request control, status checks and the cell row.
// Depends on ple_pkg, ple_cell and positional_list_engine_core_macros.svh.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+--------------------------------------
//   req     | in        | req_valid/req_stall  | mode, position, value (ple_pkg::req_t)
//   rsp     | out       | rsp_valid/rsp_stall  | status, read_value, found_position,
//           |           |                      | list_length (ple_pkg::rsp_t)
//
// From acceptance to the next possible acceptance, a request passes the launch register, the
// search token walking the row of CAPACITY cells one cell per clock, the capture into the
// result registers, the finish state and the idle state. Reset clears the entry count, the
// control state and the token chain; the entries themselves are not cleared. A response
// waits in the output register while rsp_stall is high, and the next request is already
// accepted and searched meanwhile; it finishes once the output register is free.
`include "positional_list_engine_core_macros.svh"

module positional_list_engine_core #(
    parameter int CAPACITY = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  ple_pkg::req_t     req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output ple_pkg::rsp_t     rsp
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY+1);
    // Wide enough for position, count + 1 and an 8-bit slice of either.
    localparam int PW = ((CNT_W > 8) ? CNT_W : 8) + 1;

    ple_pkg::fsm_state_t      state_reg;
    ple_pkg::fsm_state_t      state_next;
    logic                     launch_reg;
    logic                     launch_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    ple_pkg::rsp_t            rsp_reg;
    ple_pkg::rsp_t            rsp_next;

    // Request held for the duration of the search.
    ple_pkg::mode_t           mode_reg;
    logic signed [31:0]       value_reg;
    logic [IDX_W-1:0]         tgt_reg;
    ple_pkg::status_t         status_reg;

    // Search result captured at the end of the row.
    logic                     res_hit_reg;
    logic signed [31:0]       res_data_reg;
    logic [CNT_W-1:0]         res_fpos_reg;

    logic                     accept;
    logic                     fire;
    logic                     op_ok;
    logic [PW-1:0]            pos_w;
    logic [PW-1:0]            cnt_w;
    logic                     rd_bad;
    logic                     ins_bad;
    logic                     is_full;
    ple_pkg::status_t         status_new;
    logic [PW-1:0]            fpos_w;
    logic [PW-1:0]            len_w;
    ple_pkg::cell_ctl_t       ctl;

    ple_pkg::carry_t          carry [CAPACITY+1];
    logic [CNT_W-1:0]         fpos  [CAPACITY+1];
    logic signed [31:0]       entry [CAPACITY];

    assign req_stall = (state_reg != ple_pkg::S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Position checks against the current count. The position check comes before the
    // full check for insert.
    assign pos_w   = PW'(req.position);
    assign cnt_w   = PW'(count_reg);
    assign rd_bad  = (pos_w == '0) || (pos_w > cnt_w);
    assign ins_bad = (pos_w == '0) || (pos_w > (cnt_w + PW'(1)));
    assign is_full = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        case (req.mode)
            ple_pkg::MODE_GET,
            ple_pkg::MODE_DELETE:
            begin
                status_new = rd_bad ? ple_pkg::ST_BAD_POS : ple_pkg::ST_OK;
            end
            ple_pkg::MODE_INSERT:
            begin
                if (ins_bad)
                begin
                    status_new = ple_pkg::ST_BAD_POS;
                end
                else if (is_full)
                begin
                    status_new = ple_pkg::ST_FULL;
                end
                else
                begin
                    status_new = ple_pkg::ST_OK;
                end
            end
            default:
            begin
                status_new = ple_pkg::ST_OK;
            end
        endcase
    end

    // Sequencer: launch the token, wait for it at the end of the row, then commit.
    always_comb
    begin
        state_next  = state_reg;
        launch_next = 1'b0;
        fire        = 1'b0;
        case (state_reg)
            ple_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    launch_next = 1'b1;
                    state_next  = ple_pkg::S_SCAN;
                end
            end
            ple_pkg::S_SCAN:
            begin
                if (carry[CAPACITY].tok)
                begin
                    state_next = ple_pkg::S_FINISH;
                end
            end
            ple_pkg::S_FINISH:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    fire       = 1'b1;
                    state_next = ple_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ple_pkg::S_IDLE;
            end
        endcase
    end

    assign op_ok = (status_reg == ple_pkg::ST_OK);

    // The shift happens in the same cycle that the response is loaded.
    assign ctl.mode   = mode_reg;
    assign ctl.value  = value_reg;
    assign ctl.ins_en = fire && op_ok && (mode_reg == ple_pkg::MODE_INSERT);
    assign ctl.del_en = fire && op_ok && (mode_reg == ple_pkg::MODE_DELETE);

    always_comb
    begin
        count_next = count_reg;
        if (ctl.ins_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (ctl.del_en)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign fpos_w = PW'(res_fpos_reg);
    assign len_w  = PW'(count_next);

    always_comb
    begin
        rsp_next.status         = status_reg;
        rsp_next.read_value     = '0;
        rsp_next.found_position = '0;
        rsp_next.list_length    = len_w[7:0];
        if (op_ok && ((mode_reg == ple_pkg::MODE_GET) || (mode_reg == ple_pkg::MODE_DELETE)))
        begin
            rsp_next.read_value = res_data_reg;
        end
        if ((mode_reg == ple_pkg::MODE_LOCATE) && res_hit_reg)
        begin
            rsp_next.found_position = fpos_w[7:0];
        end

        rsp_valid_next = rsp_valid_reg;
        if (fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ple_pkg::S_IDLE;
            launch_reg    <= 1'b0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mode_reg   <= req.mode;
            value_reg  <= req.value;
            tgt_reg    <= IDX_W'(pos_w - PW'(1));
            status_reg <= status_new;
        end
        if ((state_reg == ple_pkg::S_SCAN) && carry[CAPACITY].tok)
        begin
            res_hit_reg  <= carry[CAPACITY].hit;
            res_data_reg <= carry[CAPACITY].data;
            res_fpos_reg <= fpos[CAPACITY];
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // The token enters the first cell in the cycle after acceptance, with no hit.
    assign carry[0].tok  = launch_reg;
    assign carry[0].hit  = 1'b0;
    assign carry[0].data = '0;
    assign fpos[0]       = '0;

    // Row of cells: on insert the target takes the new value, cells above it the left
    // neighbor; on delete the target and above take the right neighbor. The end cells
    // feed back their own entry where no neighbor exists; only the last cell's is used.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [31:0] left_entry;
        logic signed [31:0] right_entry;

        if (i == 0)
        begin : g_first
            assign left_entry = entry[i];
        end
        else
        begin : g_mid_l
            assign left_entry = entry[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_entry = entry[i];
        end
        else
        begin : g_mid_r
            assign right_entry = entry[i+1];
        end

        ple_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .tgt         (tgt_reg),
            .count       (count_reg),
            .entry_left  (left_entry),
            .entry_right (right_entry),
            .entry       (entry[i]),
            .carry_in    (carry[i]),
            .fpos_in     (fpos[i]),
            .carry_out   (carry[i+1]),
            .fpos_out    (fpos[i+1])
        );
    end

    // The count never passes the capacity.
    `PLE_ASSERT_IMP(a_count_cap, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    // The count moves only when a request finishes.
    `PLE_ASSERT_NXT(a_count_hold, clk, rst_n, state_reg != ple_pkg::S_FINISH, $stable(count_reg))
    // The token reaches the end of the row only while a search is running.
    `PLE_ASSERT_IMP(a_tok_scan, clk, rst_n, carry[CAPACITY].tok, state_reg == ple_pkg::S_SCAN)
    // A pending response reports the count that stands after it.
    `PLE_ASSERT_IMP(a_len_match, clk, rst_n, rsp_valid_reg, rsp_reg.list_length == len_w[7:0] || state_reg == ple_pkg::S_FINISH)

endmodule

// ===== tb/sv/ple_tb_pkg.sv =====
// Scoreboard for the positional list engine testbench: a shadow copy of the list
// predicts each response when a request is accepted. Depends on ple_pkg.
`timescale 1ns / 1ps

package ple_tb_pkg;

    import ple_pkg::*;

    class list_scoreboard;

        int unsigned        capacity;
        logic signed [31:0] shadow_list[$];
        rsp_t               expected_responses[$];
        int unsigned        error_count;
        int unsigned        full_count;
        int unsigned        bad_pos_count;
        int unsigned        locate_hits;
        int unsigned        peak_length;

        function new(int unsigned cap);
            capacity = cap;
        endfunction

        // Applies an accepted request to the shadow list and queues the response it must produce.
        function void note_request(req_t r);
            rsp_t        exp_rsp;
            int unsigned pos;
            int unsigned cnt;
            int unsigned k;
            exp_rsp = '0;
            exp_rsp.status = ST_OK;
            pos = r.position;
            cnt = shadow_list.size();
            case (r.mode)
                MODE_GET:
                    if (pos < 1 || pos > cnt)
                        exp_rsp.status = ST_BAD_POS;
                    else
                        exp_rsp.read_value = shadow_list[pos - 1];
                MODE_INSERT:
                    if (pos < 1 || pos > cnt + 1)
                        exp_rsp.status = ST_BAD_POS;
                    else if (cnt >= capacity)
                        exp_rsp.status = ST_FULL;
                    else
                        shadow_list.insert(pos - 1, r.value);
                MODE_DELETE:
                    if (pos < 1 || pos > cnt)
                        exp_rsp.status = ST_BAD_POS;
                    else
                    begin
                        exp_rsp.read_value = shadow_list[pos - 1];
                        shadow_list.delete(pos - 1);
                    end
                default:
                begin
                    k = 0;
                    while (k < cnt && exp_rsp.found_position == 0)
                    begin
                        if (shadow_list[k] == r.value)
                            exp_rsp.found_position = 8'(k + 1);
                        k++;
                    end
                end
            endcase
            exp_rsp.list_length = 8'(shadow_list.size());
            if (shadow_list.size() > peak_length)
                peak_length = shadow_list.size();
            expected_responses.push_back(exp_rsp);
        endfunction

        function void compare_field(string name, logic signed [31:0] exp_v,
                                    logic signed [31:0] got_v);
            if (got_v !== exp_v)
            begin
                $error("%s mismatch: expected %0d, got %0d", name, exp_v, got_v);
                error_count++;
            end
        endfunction

        // Checks an accepted response against the oldest pending prediction.
        function void check_response(rsp_t got);
            rsp_t exp_rsp;
            if (expected_responses.size() == 0)
            begin
                $error("response with no request pending: status %0d, length %0d",
                       got.status, got.list_length);
                error_count++;
                return;
            end
            exp_rsp = expected_responses.pop_front();
            case (exp_rsp.status)
                ST_FULL:    full_count++;
                ST_BAD_POS: bad_pos_count++;
                default:    ;
            endcase
            if (exp_rsp.found_position != 0)
                locate_hits++;
            compare_field("status", 32'(exp_rsp.status), 32'(got.status));
            compare_field("read_value", exp_rsp.read_value, got.read_value);
            compare_field("found_position", 32'(exp_rsp.found_position),
                          32'(got.found_position));
            compare_field("list_length", 32'(exp_rsp.list_length), 32'(got.list_length));
        endfunction

    endclass

endpackage

// ===== tb/sv/tb_positional_list_engine_core.sv =====
// Top-level testbench for positional_list_engine_core: directed and random requests with
// bursty sending and a stalling receiver. Depends on ple_pkg and ple_tb_pkg.
`timescale 1ns / 1ps

module tb_positional_list_engine_core;

    import ple_pkg::*;
    import ple_tb_pkg::*;

    localparam int unsigned LIST_CAPACITY  = 128;
    localparam int unsigned ITEM_TARGET    = 1850;
    // Each request occupies the block while its token walks the whole row, and the sender's
    // pauses and the receiver's stalls are bounded by the random ranges below, so the
    // watchdog firing can only mean a hang.
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    // Random traffic is organized in phases so that the list really fills up and
    // really empties out, instead of hovering around a short length.
    typedef enum int {
        PH_FILL,
        PH_DRAIN,
        PH_MIXED
    } phase_e;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic rsp_stall = 1'b0;
    req_t req       = '0;
    logic req_stall;
    logic rsp_valid;
    rsp_t rsp;

    list_scoreboard sb;
    int unsigned    requests_sent = 0;
    int unsigned    burst_left    = 0;
    int unsigned    stall_run     = 0;
    logic           stall_level   = 1'b0;
    int unsigned    idle_cycles   = 0;

    positional_list_engine_core #(
        .CAPACITY(LIST_CAPACITY)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp)
    );

    always #1 clk = ~clk;

    // Response side. A response counts as taken at an edge where rsp_valid is high and
    // rsp_stall is low; both are sampled before this edge's updates land. The stall
    // pattern mixes runs of stalling and runs of free flow, with random lengths,
    // so that back-pressure arrives at every point of the block's long search cycle.
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            sb.check_response(rsp);
        if (stall_run == 0)
        begin
            stall_level = ($urandom_range(0, 2) == 0);
            stall_run = stall_level ? $urandom_range(1, 160) : $urandom_range(1, 400);
        end
        stall_run--;
        rsp_stall <= stall_level;
    end

    // Watchdog: counts edges at which neither channel moves a request or a response.
    always @(posedge clk)
    begin
        if (rst_n && !((req_valid && !req_stall) || (rsp_valid && !rsp_stall)))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Timeout: no request or response moved for %0d cycles.", WATCHDOG_LIMIT);
            $display("positional_list_engine_core test failed");
            $finish;
        end
    end

    function automatic req_t make_request(mode_t m, logic [7:0] pos, logic signed [31:0] val);
        req_t r;
        r.mode = m;
        r.position = pos;
        r.value = val;
        return r;
    endfunction

    // Presents one request and holds it until the block takes it; the prediction is made
    // at the edge of acceptance, so the next request is generated from the updated list.
    task automatic send_request(input req_t r);
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        sb.note_request(r);
        requests_sent++;
    endtask

    // Sends a request as part of a burst; when the burst runs out, the sender goes
    // quiet for a random gap and then starts a new burst of random length.
    task automatic run_item(input req_t r);
        int unsigned gap;
        send_request(r);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 10) : $urandom_range(1, 140);
            req_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
            burst_left = $urandom_range(0, 40);
        end
    endtask

    // Builds a random request. Most positions are legal for the current length, with a bias
    // toward both ends of the list; the rest are mostly out of range, up to the full 8-bit field.
    // Locate mostly searches for values present in the list, and many values come from a
    // tiny pool so that duplicates appear and the first match matters.
    function automatic req_t random_request(phase_e ph);
        req_t        r;
        int unsigned cnt;
        int unsigned top;
        int unsigned pick;
        cnt = sb.shadow_list.size();
        pick = $urandom_range(0, 99);
        case (ph)
            PH_FILL:  r.mode = (pick < 70) ? MODE_INSERT : (pick < 80) ? MODE_DELETE :
                               (pick < 90) ? MODE_GET : MODE_LOCATE;
            PH_DRAIN: r.mode = (pick < 70) ? MODE_DELETE : (pick < 80) ? MODE_INSERT :
                               (pick < 90) ? MODE_GET : MODE_LOCATE;
            default:  r.mode = mode_t'($urandom_range(0, 3));
        endcase

        top = (r.mode == MODE_INSERT) ? cnt + 1 : cnt;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            case ($urandom_range(0, 4))
                0:       r.position = 8'd0;
                1:       r.position = 8'(top + 1);
                2:       r.position = 8'd128;
                3:       r.position = 8'($urandom_range(129, 255));
                default: r.position = 8'($urandom_range(0, 255));
            endcase
        end
        else if (top == 0)
            r.position = 8'd1;
        else if (pick < 22)
            r.position = 8'd1;
        else if (pick < 32)
            r.position = 8'(top);
        else
            r.position = 8'($urandom_range(1, top));

        pick = $urandom_range(0, 99);
        if (r.mode == MODE_LOCATE && cnt > 0 && pick < 55)
            r.value = sb.shadow_list[$urandom_range(0, cnt - 1)];
        else if (pick < 65)
            r.value = $urandom_range(0, 6) - 3;
        else if (pick < 78)
        begin
            case ($urandom_range(0, 3))
                0:       r.value = 32'sh8000_0000;
                1:       r.value = 32'sh7FFF_FFFF;
                2:       r.value = 32'sd0;
                default: r.value = -32'sd1;
            endcase
        end
        else
            r.value = $urandom;
        return r;
    endfunction

    initial
    begin
        phase_e      ph;
        int unsigned extra;
        sb = new(LIST_CAPACITY);
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed requests. The list after each step is noted where it changes.
        // Get and delete on an empty list, locate on an empty list, and inserts at
        // positions zero and two are all rejected or come back empty.
        send_request(make_request(MODE_GET,    8'd1,   32'sd7));
        send_request(make_request(MODE_DELETE, 8'd1,   32'sd7));
        send_request(make_request(MODE_LOCATE, 8'd0,   32'sd0));
        send_request(make_request(MODE_INSERT, 8'd0,   32'sd5));
        send_request(make_request(MODE_INSERT, 8'd2,   32'sd5));
        // Inserting into the empty list at position one is legal.
        send_request(make_request(MODE_INSERT, 8'd1,   32'sh8000_0000));   // min
        send_request(make_request(MODE_INSERT, 8'd2,   32'sh7FFF_FFFF));   // min max
        send_request(make_request(MODE_INSERT, 8'd1,   -32'sd1));          // -1 min max
        send_request(make_request(MODE_INSERT, 8'd4,   32'sd0));           // -1 min max 0
        send_request(make_request(MODE_INSERT, 8'd3,   -32'sd1));          // -1 min -1 max 0
        send_request(make_request(MODE_GET,    8'd1,   32'sd0));
        send_request(make_request(MODE_GET,    8'd5,   32'sd0));
        send_request(make_request(MODE_GET,    8'd6,   32'sd0));
        send_request(make_request(MODE_GET,    8'd0,   32'sd0));
        send_request(make_request(MODE_GET,    8'd255, -32'sd1));
        // Locate with a duplicate must report the first match.
        send_request(make_request(MODE_LOCATE, 8'd255, -32'sd1));
        send_request(make_request(MODE_LOCATE, 8'd0,   32'sh7FFF_FFFF));
        send_request(make_request(MODE_LOCATE, 8'd1,   32'sd12345));
        send_request(make_request(MODE_DELETE, 8'd3,   32'sd0));           // -1 min max 0
        send_request(make_request(MODE_DELETE, 8'd4,   32'sd0));           // -1 min max
        send_request(make_request(MODE_DELETE, 8'd0,   32'sd0));
        send_request(make_request(MODE_DELETE, 8'd128, 32'sd0));
        send_request(make_request(MODE_INSERT, 8'd255, 32'shAAAA_5555));
        // Zero is no longer in the list, so locate must not find it.
        send_request(make_request(MODE_LOCATE, 8'd2,   32'sd0));
        send_request(make_request(MODE_GET,    8'd2,   32'sh5555_AAAA));

        // Random phases. Fill runs until the list is full and then keeps pushing so that
        // full-list rejections and bad positions at full length both occur; drain runs
        // until the list is empty and then keeps going a little.
        while (requests_sent < ITEM_TARGET)
        begin
            ph = phase_e'($urandom_range(0, 2));
            case (ph)
                PH_FILL:
                begin
                    extra = $urandom_range(5, 30);
                    while (requests_sent < ITEM_TARGET && extra > 0)
                    begin
                        run_item(random_request(ph));
                        if (sb.shadow_list.size() == LIST_CAPACITY)
                            extra--;
                    end
                end
                PH_DRAIN:
                begin
                    extra = $urandom_range(3, 15);
                    while (requests_sent < ITEM_TARGET && extra > 0)
                    begin
                        run_item(random_request(ph));
                        if (sb.shadow_list.size() == 0)
                            extra--;
                    end
                end
                default:
                begin
                    extra = $urandom_range(60, 200);
                    while (requests_sent < ITEM_TARGET && extra > 0)
                    begin
                        run_item(random_request(ph));
                        extra--;
                    end
                end
            endcase
        end
        req_valid <= 1'b0;

        // Drain the outstanding responses, then watch a little longer for strays.
        while (sb.expected_responses.size() != 0)
            @(posedge clk);
        repeat (LIST_CAPACITY + 8)
            @(posedge clk);

        $display("Sent %0d requests through fill, drain and mixed phases; the list peaked at %0d of %0d entries.",
                 requests_sent, sb.peak_length, LIST_CAPACITY);
        $display("Saw %0d full-list rejections, %0d bad positions and %0d locate hits.",
                 sb.full_count, sb.bad_pos_count, sb.locate_hits);
        if (sb.error_count == 0)
            $display("positional_list_engine_core test passed");
        else
            $display("positional_list_engine_core test failed");
        $finish;
    end

endmodule

// ===== positional_list_engine_core.f =====
+incdir+src
src/ple_pkg.sv
src/ple_cell.sv
src/positional_list_engine_core.sv
tb/sv/ple_tb_pkg.sv
tb/sv/tb_positional_list_engine_core.sv
